>>> rtl/core/mvcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mvcc_pkg;

    // Default width of a transaction id
    localparam int ID_BITS_DEF = 8;

    // Field widths on the stream ports
    localparam int CMD_W    = 3;
    localparam int FIELD_W  = 8;
    localparam int STATUS_W = 2;
    localparam int VIS_W    = 2;
    localparam int TXST_W   = 2;

    // Slave tdata layout: txn_id, created_by, has_deleter, deleted_by
    localparam int S_ID_LSB   = 0;
    localparam int S_CRE_LSB  = S_ID_LSB + FIELD_W;
    localparam int S_HDEL_BIT = S_CRE_LSB + FIELD_W;
    localparam int S_DEL_LSB  = S_HDEL_BIT + 1;
    localparam int S_USED_W   = S_DEL_LSB + FIELD_W;
    localparam int S_TDATA_W  = ((S_USED_W + 7) / 8) * 8;

    // Master tdata layout: status, new_txn_id, visibility
    localparam int M_STAT_LSB = 0;
    localparam int M_NEW_LSB  = M_STAT_LSB + STATUS_W;
    localparam int M_VIS_LSB  = M_NEW_LSB + FIELD_W;
    localparam int M_USED_W   = M_VIS_LSB + VIS_W;
    localparam int M_TDATA_W  = ((M_USED_W + 7) / 8) * 8;

    // Commands
    localparam logic [CMD_W-1:0] CMD_BEGIN    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_COMMIT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ROLLBACK = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CHECK    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLASSIFY = 3'd4;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;

    // Visibility codes
    localparam logic [VIS_W-1:0] VIS_INVISIBLE = 2'd0;
    localparam logic [VIS_W-1:0] VIS_VISIBLE   = 2'd1;
    localparam logic [VIS_W-1:0] VIS_DELETED   = 2'd2;

    // Transaction states held in the table
    localparam logic [TXST_W-1:0] TX_ACTIVE    = 2'd0;
    localparam logic [TXST_W-1:0] TX_COMMITTED = 2'd1;
    localparam logic [TXST_W-1:0] TX_ABORTED   = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_FIRST,
        S_SECOND,
        S_THIRD
    } seq_state_t;

    // Table access strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

    // One result beat
    typedef struct packed {
        logic [VIS_W-1:0]    visibility;
        logic [FIELD_W-1:0]  new_txn_id;
        logic [STATUS_W-1:0] status;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/core/mvcc_tbl.sv
`timescale 1ns / 1ps
`default_nettype none

module mvcc_tbl #(
    parameter int ID_BITS = mvcc_pkg::ID_BITS_DEF,
    localparam int ENT_W  = mvcc_pkg::TXST_W + 2 * ID_BITS
) (
    input  wire logic                 clk,
    input  wire mvcc_pkg::mem_ctl_t   ctl,
    input  wire logic [ID_BITS-1:0]   addr,
    input  wire logic [ENT_W-1:0]     wdata,
    output logic      [ENT_W-1:0]     rdata
);

    localparam int DEPTH = 1 << ID_BITS;

    // Status table: {commit stamp, snapshot, state} per id
    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] rdata_reg;

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/mvcc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mvcc_ctrl #(
    parameter int ID_BITS = mvcc_pkg::ID_BITS_DEF,
    localparam int ENT_W  = mvcc_pkg::TXST_W + 2 * ID_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // item side
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [mvcc_pkg::CMD_W-1:0]      in_cmd,
    input  wire logic [mvcc_pkg::FIELD_W-1:0]    in_txn_id,
    input  wire logic [mvcc_pkg::FIELD_W-1:0]    in_created_by,
    input  wire logic                            in_has_deleter,
    input  wire logic [mvcc_pkg::FIELD_W-1:0]    in_deleted_by,
    // result side
    input  wire logic                            out_free,
    output logic                                 res_valid,
    output mvcc_pkg::result_t                    res,
    // table port
    output mvcc_pkg::mem_ctl_t                   mem_ctl,
    output logic [ID_BITS-1:0]                   mem_addr,
    output logic [ENT_W-1:0]                     mem_wdata,
    input  wire logic [ENT_W-1:0]                mem_rdata
);

    localparam int TXST_W   = mvcc_pkg::TXST_W;
    localparam int SNAP_LSB = TXST_W;
    localparam int STMP_LSB = TXST_W + ID_BITS;

    mvcc_pkg::seq_state_t state_reg, state_next;

    logic                           acc;
    logic [mvcc_pkg::CMD_W-1:0]     cmd_reg;
    logic [ID_BITS-1:0]             id_reg, cre_reg, del_reg;
    logic                           hdel_reg;
    logic [ENT_W-1:0]               r_ent_reg, r_ent_next;
    logic [ENT_W-1:0]               c_ent_reg, c_ent_next;
    logic [ID_BITS:0]               next_id_reg, next_id_next;
    logic [ID_BITS-1:0]             ctr_reg, ctr_next;

    logic [TXST_W-1:0]              rd_state, r_state, c_state;
    logic [ID_BITS-1:0]             rd_snap, r_snap, c_stamp, d_stamp;
    logic                           full, id_active;
    logic                           r_ok, c_ok, c_seen, d_ok, d_seen;
    logic [mvcc_pkg::VIS_W-1:0]     vis;

    // id is allocated: 1 <= id < next_id
    function automatic logic known(input logic [ID_BITS-1:0] id,
                                   input logic [ID_BITS:0]   nxt);
        return (id != '0) && ({1'b0, id} < nxt);
    endfunction

    assign acc      = in_valid && in_ready;
    assign in_ready = (state_reg == mvcc_pkg::S_IDLE);

    // Entry fields
    assign rd_state = mem_rdata[TXST_W-1:0];
    assign rd_snap  = mem_rdata[SNAP_LSB +: ID_BITS];
    assign r_state  = r_ent_reg[TXST_W-1:0];
    assign r_snap   = r_ent_reg[SNAP_LSB +: ID_BITS];
    assign c_state  = c_ent_reg[TXST_W-1:0];
    assign c_stamp  = c_ent_reg[STMP_LSB +: ID_BITS];
    assign d_stamp  = mem_rdata[STMP_LSB +: ID_BITS];

    assign full      = next_id_reg[ID_BITS];
    assign id_active = known(id_reg, next_id_reg) && (rd_state == mvcc_pkg::TX_ACTIVE);

    // Visibility of a version; deleter entry arrives on the read port
    always_comb
    begin
        r_ok   = known(id_reg, next_id_reg) && (r_state != mvcc_pkg::TX_ABORTED);
        c_ok   = known(cre_reg, next_id_reg) && (c_state != mvcc_pkg::TX_ABORTED);
        c_seen = (cre_reg == id_reg)
              || ((c_state == mvcc_pkg::TX_COMMITTED) && (c_stamp <= r_snap));
        d_ok   = known(del_reg, next_id_reg) && (rd_state != mvcc_pkg::TX_ABORTED);
        d_seen = (del_reg == id_reg)
              || ((rd_state == mvcc_pkg::TX_COMMITTED) && (d_stamp <= r_snap));
        if (!r_ok || !c_ok || !c_seen)
        begin
            vis = mvcc_pkg::VIS_INVISIBLE;
        end
        else if (!hdel_reg || !d_ok || !d_seen)
        begin
            vis = mvcc_pkg::VIS_VISIBLE;
        end
        else
        begin
            vis = mvcc_pkg::VIS_DELETED;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mvcc_pkg::S_IDLE:
            begin
                if (acc)
                begin
                    state_next = mvcc_pkg::S_FIRST;
                end
            end
            mvcc_pkg::S_FIRST:
            begin
                if (cmd_reg == mvcc_pkg::CMD_CLASSIFY)
                begin
                    state_next = mvcc_pkg::S_SECOND;
                end
                else if (out_free)
                begin
                    state_next = mvcc_pkg::S_IDLE;
                end
            end
            mvcc_pkg::S_SECOND:
            begin
                state_next = mvcc_pkg::S_THIRD;
            end
            mvcc_pkg::S_THIRD:
            begin
                if (out_free)
                begin
                    state_next = mvcc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mvcc_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs: table accesses, results and counter updates
    always_comb
    begin
        mem_ctl        = '0;
        mem_addr       = ID_BITS'(in_txn_id);
        mem_wdata      = '0;
        res_valid      = 1'b0;
        res.status     = mvcc_pkg::STAT_IGNORED;
        res.new_txn_id = '0;
        res.visibility = mvcc_pkg::VIS_INVISIBLE;
        next_id_next   = next_id_reg;
        ctr_next       = ctr_reg;
        r_ent_next     = r_ent_reg;
        c_ent_next     = c_ent_reg;
        case (state_reg)
            mvcc_pkg::S_IDLE:
            begin
                // fetch the target or reader entry with the beat
                mem_ctl.rd_en = acc;
            end
            mvcc_pkg::S_FIRST:
            begin
                res_valid = out_free && (cmd_reg != mvcc_pkg::CMD_CLASSIFY);
                case (cmd_reg)
                    mvcc_pkg::CMD_BEGIN:
                    begin
                        if (full)
                        begin
                            res.status = mvcc_pkg::STAT_FULL;
                        end
                        else
                        begin
                            res.status     = mvcc_pkg::STAT_OK;
                            res.new_txn_id = mvcc_pkg::FIELD_W'(next_id_reg);
                            mem_ctl.wr_en  = out_free;
                            mem_addr       = next_id_reg[ID_BITS-1:0];
                            mem_wdata      = {{ID_BITS{1'b0}}, ctr_reg, mvcc_pkg::TX_ACTIVE};
                            if (out_free)
                            begin
                                next_id_next = next_id_reg + 1'b1;
                            end
                        end
                    end
                    mvcc_pkg::CMD_COMMIT:
                    begin
                        mem_addr  = id_reg;
                        mem_wdata = {ctr_reg + 1'b1, rd_snap, mvcc_pkg::TX_COMMITTED};
                        if (id_active)
                        begin
                            res.status    = mvcc_pkg::STAT_OK;
                            mem_ctl.wr_en = out_free;
                            if (out_free)
                            begin
                                ctr_next = ctr_reg + 1'b1;
                            end
                        end
                    end
                    mvcc_pkg::CMD_ROLLBACK:
                    begin
                        mem_addr  = id_reg;
                        mem_wdata = {mem_rdata[ENT_W-1:TXST_W], mvcc_pkg::TX_ABORTED};
                        if (id_active)
                        begin
                            res.status    = mvcc_pkg::STAT_OK;
                            mem_ctl.wr_en = out_free;
                        end
                    end
                    mvcc_pkg::CMD_CHECK:
                    begin
                        if (id_active)
                        begin
                            res.status = mvcc_pkg::STAT_OK;
                        end
                    end
                    mvcc_pkg::CMD_CLASSIFY:
                    begin
                        // keep the reader entry, fetch the creator
                        r_ent_next    = mem_rdata;
                        mem_ctl.rd_en = 1'b1;
                        mem_addr      = cre_reg;
                    end
                    default:
                    begin
                        res.status = mvcc_pkg::STAT_IGNORED;
                    end
                endcase
            end
            mvcc_pkg::S_SECOND:
            begin
                // keep the creator entry, fetch the deleter
                c_ent_next    = mem_rdata;
                mem_ctl.rd_en = 1'b1;
                mem_addr      = del_reg;
            end
            mvcc_pkg::S_THIRD:
            begin
                res_valid      = out_free;
                res.status     = mvcc_pkg::STAT_OK;
                res.visibility = vis;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mvcc_pkg::S_IDLE;
            next_id_reg <= (ID_BITS + 1)'(1);
            ctr_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            next_id_reg <= next_id_next;
            ctr_reg     <= ctr_next;
        end
    end

    // Item and entry holding registers
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            cmd_reg  <= in_cmd;
            id_reg   <= ID_BITS'(in_txn_id);
            cre_reg  <= ID_BITS'(in_created_by);
            hdel_reg <= in_has_deleter;
            del_reg  <= ID_BITS'(in_deleted_by);
        end
        r_ent_reg <= r_ent_next;
        c_ent_reg <= c_ent_next;
    end

endmodule

`default_nettype wire

>>> rtl/core/mvcc_txn_status_and_visibility.sv
// MVCC transaction status table with snapshot-isolation visibility check.
// Input channel s_*: one beat per command, cmd on s_tuser, operands on s_tdata.
// Output channel m_*: exactly one result beat per input beat, in order.
// Begin, commit, rollback, check and unused commands: the table entry is read
// on the accept edge, and any update is written in S_FIRST when the result is
// loaded into the output register that drives m_tvalid; the next beat is not
// accepted until the sequencer is back in S_IDLE.
// Classify reads reader, creator and deleter entries in turn through the one
// port of the status memory, in S_IDLE, S_FIRST and S_SECOND, and loads its
// result in S_THIRD; the next beat is not accepted until S_IDLE again.
// A result waiting in the output register does not block acceptance of the
// next beat; the following result waits in the sequencer while m_tready is
// low, holding the table untouched until it can be loaded.
// Reset clears the sequencer, the id allocator (next id 1) and the commit
// counter; the table itself is not cleared, as only entries of allocated ids are used.
// No clearing pass is needed, so the block is ready straight after reset.
`timescale 1ns / 1ps
`default_nettype none

module mvcc_txn_status_and_visibility #(
    parameter int ID_BITS = mvcc_pkg::ID_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // txn_id[7:0], created_by[15:8], has_deleter[16], deleted_by[24:17]
    input  wire logic [mvcc_pkg::S_TDATA_W-1:0]    s_tdata,
    // cmd[2:0]
    input  wire logic [mvcc_pkg::CMD_W-1:0]        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // status[1:0], new_txn_id[9:2], visibility[11:10]
    output logic [mvcc_pkg::M_TDATA_W-1:0]         m_tdata
);

    localparam int ENT_W = mvcc_pkg::TXST_W + 2 * ID_BITS;

    mvcc_pkg::mem_ctl_t    mem_ctl;
    logic [ID_BITS-1:0]    mem_addr;
    logic [ENT_W-1:0]      mem_wdata, mem_rdata;
    logic                  out_free, res_valid;
    mvcc_pkg::result_t     res;
    logic                  out_valid_reg, out_valid_next;
    mvcc_pkg::result_t     out_reg;

    assign out_free = !out_valid_reg || m_tready;

    mvcc_ctrl #(
        .ID_BITS (ID_BITS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .in_cmd         (s_tuser),
        .in_txn_id      (s_tdata[mvcc_pkg::S_ID_LSB +: mvcc_pkg::FIELD_W]),
        .in_created_by  (s_tdata[mvcc_pkg::S_CRE_LSB +: mvcc_pkg::FIELD_W]),
        .in_has_deleter (s_tdata[mvcc_pkg::S_HDEL_BIT]),
        .in_deleted_by  (s_tdata[mvcc_pkg::S_DEL_LSB +: mvcc_pkg::FIELD_W]),
        .out_free       (out_free),
        .res_valid      (res_valid),
        .res            (res),
        .mem_ctl        (mem_ctl),
        .mem_addr       (mem_addr),
        .mem_wdata      (mem_wdata),
        .mem_rdata      (mem_rdata)
    );

    mvcc_tbl #(
        .ID_BITS (ID_BITS)
    ) u_tbl (
        .clk   (clk),
        .ctl   (mem_ctl),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Output register
    always_comb
    begin
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(mvcc_pkg::M_TDATA_W - mvcc_pkg::M_USED_W){1'b0}}, out_reg};

endmodule

`default_nettype wire

>>> rtl/core/mvcc_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module mvcc_chk (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    input  wire logic [mvcc_pkg::M_TDATA_W-1:0]    m_tdata
);

    logic [mvcc_pkg::STATUS_W-1:0] st;
    logic [mvcc_pkg::FIELD_W-1:0]  nid;
    logic [mvcc_pkg::VIS_W-1:0]    vis;

    assign st  = m_tdata[mvcc_pkg::M_STAT_LSB +: mvcc_pkg::STATUS_W];
    assign nid = m_tdata[mvcc_pkg::M_NEW_LSB +: mvcc_pkg::FIELD_W];
    assign vis = m_tdata[mvcc_pkg::M_VIS_LSB +: mvcc_pkg::VIS_W];

    // Stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // Only one beat in the sequencer at a time
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("beat accepted while another is in work");

    // A new id only comes with a successful begin
    a_nid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (nid != '0) |-> (st == mvcc_pkg::STAT_OK) && (vis == '0))
        else $error("new id on a failed or non-begin result");

    // Visibility only comes with status OK, and no unused codes appear
    a_vis: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (st != 2'd3) && (vis != 2'd3)
                  && ((vis == mvcc_pkg::VIS_INVISIBLE) || (st == mvcc_pkg::STAT_OK)))
        else $error("bad status or visibility code");

endmodule

bind mvcc_txn_status_and_visibility mvcc_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> tb/mvcc_txn_status_and_visibility_tb.sv
`timescale 1ns / 1ps

module mvcc_txn_status_and_visibility_tb;

    import mvcc_pkg::*;

    localparam int MAX_ID      = (1 << ID_BITS_DEF) - 1;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 10;
    localparam int RANDOM_CMDS = 720;

    // Command codes the block leaves unused
    localparam logic [CMD_W-1:0] CMD_RSVD_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_C = 3'd7;

    // Mirror of the transaction table and the results it predicts
    class txn_table_mirror;
        logic [ID_BITS_DEF:0]   next_id;
        logic [FIELD_W-1:0]     commit_ctr;
        logic [TXST_W-1:0]      tx_state [MAX_ID+1];
        logic [FIELD_W-1:0]     snap_ts [MAX_ID+1];
        logic [FIELD_W-1:0]     stamp [MAX_ID+1];
        result_t                awaited_results [$];
        int                     errors;

        function new();
            next_id    = (ID_BITS_DEF + 1)'(1);
            commit_ctr = '0;
            errors     = 0;
            foreach (tx_state[i])
            begin
                tx_state[i] = TX_ACTIVE;
                snap_ts[i]  = '0;
                stamp[i]    = '0;
            end
        endfunction

        function bit known(logic [FIELD_W-1:0] id);
            return id != 0 && {1'b0, id} < next_id;
        endfunction

        function bit is_active(logic [FIELD_W-1:0] id);
            return known(id) && tx_state[id] == TX_ACTIVE;
        endfunction

        // A write by w is seen by reader r: own write, or committed inside r's snapshot
        function bit write_seen(logic [FIELD_W-1:0] w, logic [FIELD_W-1:0] r);
            return w == r || (tx_state[w] == TX_COMMITTED && stamp[w] <= snap_ts[r]);
        endfunction

        function logic [VIS_W-1:0] judge_version(logic [FIELD_W-1:0] rdr,
                                                  logic [FIELD_W-1:0] cre,
                                                  logic hdel,
                                                  logic [FIELD_W-1:0] del);
            if (!known(rdr) || tx_state[rdr] == TX_ABORTED)
                return VIS_INVISIBLE;
            if (!known(cre) || tx_state[cre] == TX_ABORTED)
                return VIS_INVISIBLE;
            if (!write_seen(cre, rdr))
                return VIS_INVISIBLE;
            if (!hdel || !known(del) || tx_state[del] == TX_ABORTED)
                return VIS_VISIBLE;
            return write_seen(del, rdr) ? VIS_DELETED : VIS_VISIBLE;
        endfunction

        function bit table_full();
            return next_id > MAX_ID;
        endfunction

        // Accepted command: update the mirror and queue its result
        function void note_command(logic [CMD_W-1:0] cmd, logic [FIELD_W-1:0] id,
                                   logic [FIELD_W-1:0] cre, logic hdel,
                                   logic [FIELD_W-1:0] del);
            result_t res;
            res.status     = STAT_IGNORED;
            res.new_txn_id = '0;
            res.visibility = VIS_INVISIBLE;
            case (cmd)
                CMD_BEGIN:
                begin
                    if (table_full())
                        res.status = STAT_FULL;
                    else
                    begin
                        res.new_txn_id = next_id[FIELD_W-1:0];
                        tx_state[res.new_txn_id] = TX_ACTIVE;
                        snap_ts[res.new_txn_id]  = commit_ctr;
                        stamp[res.new_txn_id]    = '0;
                        next_id    = next_id + 1'b1;
                        res.status = STAT_OK;
                    end
                end
                CMD_COMMIT:
                begin
                    if (is_active(id))
                    begin
                        commit_ctr   = commit_ctr + 1'b1;
                        tx_state[id] = TX_COMMITTED;
                        stamp[id]    = commit_ctr;
                        res.status   = STAT_OK;
                    end
                end
                CMD_ROLLBACK:
                begin
                    if (is_active(id))
                    begin
                        tx_state[id] = TX_ABORTED;
                        res.status   = STAT_OK;
                    end
                end
                CMD_CHECK:
                begin
                    if (is_active(id))
                        res.status = STAT_OK;
                end
                CMD_CLASSIFY:
                begin
                    res.visibility = judge_version(id, cre, hdel, del);
                    res.status     = STAT_OK;
                end
                default: ;
            endcase
            awaited_results.push_back(res);
        endfunction

        // Result beat: compare against the oldest prediction
        function void check_result(logic [M_TDATA_W-1:0] beat);
            result_t got;
            result_t want;
            got = result_t'(beat[M_USED_W-1:0]);
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result beat 0x%0h", beat);
                errors++;
                return;
            end
            want = awaited_results.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.new_txn_id !== want.new_txn_id)
            begin
                $error("new_txn_id: expected %0d, got %0d", want.new_txn_id, got.new_txn_id);
                errors++;
            end
            if (got.visibility !== want.visibility)
            begin
                $error("visibility: expected %0d, got %0d", want.visibility, got.visibility);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic [CMD_W-1:0]       s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    txn_table_mirror        mirror = new();
    int                     quiet_cycles = 0;
    int                     stall_left = 0;
    int                     stall_pct = 20;

    mvcc_txn_status_and_visibility i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Receiver back-pressure; the stall rate itself drifts, zero included
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ($urandom_range(0, 149) == 0)
                stall_pct <= $urandom_range(0, 3) * 20;
            if (stall_left != 0)
            begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if ($urandom_range(0, 99) < stall_pct)
            begin
                m_tready   <= 1'b0;
                stall_left <= pick_gap();
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Result monitor and activity count for the watchdog
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            mirror.check_result(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // One command beat; valid stays high into the next beat when there is no gap
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [FIELD_W-1:0] id,
                            input logic [FIELD_W-1:0] cre, input logic hdel,
                            input logic [FIELD_W-1:0] del, input int gap);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[S_ID_LSB +: FIELD_W]  = id;
        word[S_CRE_LSB +: FIELD_W] = cre;
        word[S_HDEL_BIT]           = hdel;
        word[S_DEL_LSB +: FIELD_W] = del;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        mirror.note_command(cmd, id, cre, hdel, del);
    endtask

    task automatic directed_cmd(input logic [CMD_W-1:0] cmd, input logic [FIELD_W-1:0] id,
                                input logic [FIELD_W-1:0] cre, input logic hdel,
                                input logic [FIELD_W-1:0] del);
        send_cmd(cmd, id, cre, hdel, del, pick_gap());
    endtask

    // Hold the sender until every outstanding result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (mirror.awaited_results.size() != 0);
    endtask

    // Mostly ids already handed out, biased to recent ones, sometimes anything
    function automatic logic [FIELD_W-1:0] pick_id();
        int hi;
        int lo;
        hi = int'(mirror.next_id) - 1;
        if (hi < 1 || $urandom_range(0, 9) == 0)
            return FIELD_W'($urandom_range(0, MAX_ID));
        if ($urandom_range(0, 9) < 6)
        begin
            lo = (hi > 12) ? hi - 12 : 1;
            return FIELD_W'($urandom_range(lo, hi));
        end
        return FIELD_W'($urandom_range(1, hi));
    endfunction

    task automatic random_cmd(input int gap);
        logic [CMD_W-1:0]   cmd;
        int                 r;
        r = $urandom_range(0, 99);
        if (r < 38)
            cmd = CMD_BEGIN;
        else if (r < 58)
            cmd = CMD_COMMIT;
        else if (r < 68)
            cmd = CMD_ROLLBACK;
        else if (r < 76)
            cmd = CMD_CHECK;
        else if (r < 97)
            cmd = CMD_CLASSIFY;
        else
            cmd = CMD_W'($urandom_range(CMD_RSVD_A, CMD_RSVD_C));
        send_cmd(cmd, pick_id(), pick_id(), 1'($urandom_range(0, 1)), pick_id(), gap);
    endtask

    initial
    begin
        int gap;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unknown ids before anything is allocated, then three begins allocate ids 1 to 3
        directed_cmd(CMD_CHECK, 8'd0, 8'd0, 1'b0, 8'd0);
        directed_cmd(CMD_CLASSIFY, 8'd255, 8'd255, 1'b1, 8'd255);
        directed_cmd(CMD_COMMIT, 8'd1, 8'd0, 1'b0, 8'd0);
        directed_cmd(CMD_ROLLBACK, 8'd255, 8'd0, 1'b0, 8'd0);
        directed_cmd(CMD_BEGIN, 8'd0, 8'd0, 1'b0, 8'd0);
        directed_cmd(CMD_BEGIN, 8'd255, 8'd255, 1'b1, 8'd255);
        directed_cmd(CMD_BEGIN, 8'd0, 8'd0, 1'b0, 8'd0);
        // Own writes and own deletes
        directed_cmd(CMD_CLASSIFY, 8'd1, 8'd1, 1'b0, 8'd0);
        directed_cmd(CMD_CLASSIFY, 8'd1, 8'd1, 1'b1, 8'd1);
        directed_cmd(CMD_CLASSIFY, 8'd2, 8'd1, 1'b0, 8'd0);
        // Commit, then a second commit of the same id is ignored
        directed_cmd(CMD_COMMIT, 8'd1, 8'd0, 1'b0, 8'd0);
        directed_cmd(CMD_COMMIT, 8'd1, 8'd0, 1'b0, 8'd0);
        directed_cmd(CMD_CLASSIFY, 8'd2, 8'd1, 1'b0, 8'd0);
        directed_cmd(CMD_BEGIN, 8'd0, 8'd0, 1'b0, 8'd0);
        directed_cmd(CMD_CLASSIFY, 8'd4, 8'd1, 1'b1, 8'd2);
        // Rollback, repeated rollback, check
        directed_cmd(CMD_ROLLBACK, 8'd2, 8'd0, 1'b0, 8'd0);
        directed_cmd(CMD_ROLLBACK, 8'd2, 8'd0, 1'b0, 8'd0);
        directed_cmd(CMD_CHECK, 8'd2, 8'd0, 1'b0, 8'd0);
        directed_cmd(CMD_CHECK, 8'd3, 8'd0, 1'b0, 8'd0);
        // Aborted reader, creator and deleter
        directed_cmd(CMD_CLASSIFY, 8'd2, 8'd1, 1'b0, 8'd0);
        directed_cmd(CMD_CLASSIFY, 8'd4, 8'd2, 1'b0, 8'd0);
        directed_cmd(CMD_CLASSIFY, 8'd4, 8'd1, 1'b1, 8'd2);
        // Delete committed after the snapshot; committed reader judged by snapshot
        directed_cmd(CMD_COMMIT, 8'd3, 8'd0, 1'b0, 8'd0);
        directed_cmd(CMD_CLASSIFY, 8'd4, 8'd1, 1'b1, 8'd3);
        directed_cmd(CMD_CLASSIFY, 8'd3, 8'd1, 1'b1, 8'd200);
        // Unused commands with all fields at ones
        directed_cmd(CMD_RSVD_A, 8'd255, 8'd255, 1'b1, 8'd255);
        directed_cmd(CMD_RSVD_C, 8'd255, 8'd255, 1'b1, 8'd255);
        drain_results();

        // Random traffic, with bursts free of idling and one full drain
        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            gap = (i % 150 < 30) ? 0 : pick_gap();
            random_cmd(gap);
            if (i == RANDOM_CMDS / 2)
                drain_results();
        end

        // Make sure the id space runs out, then hit it twice more
        while (!mirror.table_full())
            send_cmd(CMD_BEGIN, FIELD_W'($urandom_range(0, MAX_ID)), 8'd0, 1'b0, 8'd0,
                     pick_gap());
        directed_cmd(CMD_BEGIN, 8'd0, 8'd0, 1'b0, 8'd0);
        directed_cmd(CMD_BEGIN, 8'd255, 8'd255, 1'b1, 8'd255);
        for (int i = 0; i < 30; i++)
            random_cmd(pick_gap());

        drain_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mirror.errors == 0 && mirror.awaited_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/mvcc_pkg.sv
rtl/core/mvcc_tbl.sv
rtl/core/mvcc_ctrl.sv
rtl/core/mvcc_txn_status_and_visibility.sv
rtl/core/mvcc_chk.sv
tb/mvcc_txn_status_and_visibility_tb.sv
